// ===== rtl/irq_least_loaded_core_router_assert.svh =====
// ============================================================================
// Assertion macros for the least-loaded core router
// Implication checks that compile away when SYNTH is defined.
// ============================================================================
`ifndef IRQ_LEAST_LOADED_CORE_ROUTER_ASSERT_SVH
`define IRQ_LEAST_LOADED_CORE_ROUTER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication check.
`define LILR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication check.
`define LILR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define LILR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LILR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lilr_pkg.sv =====
// ============================================================================
// lilr_pkg
// Shared constants and types for the least-loaded interrupt core router.
// ============================================================================
package lilr_pkg;

    // Field and register widths.
    localparam int CNT_W      = 64;
    localparam int PERIOD_W   = 16;
    localparam int ACT_W      = 5;
    localparam int FIELD_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Counter limits.
    localparam logic [CNT_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] NEAR_FULL = 64'hFFFF_FFFF_FFFF_FFFE;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYM_IO_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CORES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_PERIOD = 2'd3;

    // Remainder unit: dividend bits retired per cycle, and steps per item.
    localparam int MOD_DIGIT  = 4;
    localparam int MOD_STEPS  = CNT_W / MOD_DIGIT;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);

    // Request to the remainder unit.
    typedef struct packed {
        logic                start;
        logic [CNT_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_mod_req;

    // Status from the remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_rsp;

endpackage

// ===== rtl/lilr_count_mem.sv =====
// ============================================================================
// lilr_count_mem
// Service count table: one port, one write and one registered read per cycle.
// ============================================================================
module lilr_count_mem
    import lilr_pkg::*;
#(
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [CNT_W-1:0]  i_wdata,
    output logic [CNT_W-1:0]  o_rdata
);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    // Write port and registered read at the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lilr_mod_unit.sv =====
// ============================================================================
// lilr_mod_unit
// Iterative remainder unit: retires four dividend bits per cycle and flags
// whether the 64-bit count is an exact multiple of the 16-bit period.
// ============================================================================
module lilr_mod_unit
    import lilr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [MOD_STEP_W-1:0] r_step;
    logic [CNT_W-1:0]      r_dvd;
    logic [PERIOD_W-1:0]   r_div;
    logic [PERIOD_W-1:0]   r_rem;

    logic [CNT_W-1:0]      n_dvd;
    logic [PERIOD_W-1:0]   n_rem;

    // One restoring step per dividend bit, four bits in this cycle.
    always_comb begin
        logic [PERIOD_W:0] v_trial;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int k = 0; k < MOD_DIGIT; k++) begin
            v_trial = {n_rem, n_dvd[CNT_W-1]};
            n_dvd   = {n_dvd[CNT_W-2:0], 1'b0};
            if (v_trial >= {1'b0, r_div}) begin
                v_trial = v_trial - {1'b0, r_div};
            end
            n_rem = v_trial[PERIOD_W-1:0];
        end
    end

    // Sequencing of the shared step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == MOD_STEP_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

// ===== rtl/irq_least_loaded_core_router.sv =====
// ============================================================================
// irq_least_loaded_core_router
// Counts serviced interrupts per core and IRQ, picks the end-of-interrupt
// target and periodically reroutes an IRQ to its least loaded core.
// ============================================================================
//
//  Channel  Handshake              Word
//  -------  ---------------------  -------------------------------------------
//  input    i_valid / o_ready      i_irq_line, i_core_id
//  output   o_valid / i_ready      o_eoi_to_local_apic, o_route_valid,
//                                  o_route_core, o_counts_cleared
//  config   i_cfg_we               i_cfg_index, i_cfg_data
//
// After reset the table is cleared one entry a cycle, all MAX_CORES*MAX_IRQS
// entries in turn; o_ready stays low meanwhile.
// An item goes from S_INC to S_EMIT without a rebalance check. With the
// remainder check it waits in S_MOD on the shared unit (sixteen four-bit
// steps and its done flag), reads and compares each scanned core in turn
// (one table port) and wipes MAX_CORES entries when the IRQ's counts are
// cleared. One item is in work at a time; a new word is taken while the
// previous result still waits in the output register.
// ============================================================================
`include "irq_least_loaded_core_router_assert.svh"

module irq_least_loaded_core_router
    import lilr_pkg::*;
#(
    parameter int MAX_CORES = 16,
    parameter int MAX_IRQS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FIELD_W-1:0]    i_irq_line,
    input  logic [FIELD_W-1:0]    i_core_id,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_eoi_to_local_apic,
    output logic                  o_route_valid,
    output logic [FIELD_W-1:0]    o_route_core,
    output logic                  o_counts_cleared
);

    localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int IRQ_W  = (MAX_IRQS > 1) ? $clog2(MAX_IRQS) : 1;
    localparam int DEPTH  = MAX_CORES * MAX_IRQS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_INC      = 8'b0000_0100,
        S_MOD      = 8'b0000_1000,
        S_SCAN_RD  = 8'b0001_0000,
        S_SCAN_CMP = 8'b0010_0000,
        S_WIPE     = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    // Configuration registers.
    logic                r_sym_io_mode;
    logic                r_balance_en;
    logic [ACT_W-1:0]    r_active_cores;
    logic [PERIOD_W-1:0] r_balance_period;

    // Sequencer state.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CORE_W-1:0]   r_scan, n_scan;
    logic [IRQ_W-1:0]    r_irq, n_irq;
    logic [CORE_W-1:0]   r_core, n_core;
    logic                r_eoi, n_eoi;
    logic [CNT_W-1:0]    r_best, n_best;
    logic [CORE_W-1:0]   r_best_core, n_best_core;
    logic                r_clear, n_clear;
    logic                r_res_route_valid, n_res_route_valid;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic                r_out_eoi, n_out_eoi;
    logic                r_out_route_valid, n_out_route_valid;
    logic [FIELD_W-1:0]  r_out_route, n_out_route;
    logic                r_out_cleared, n_out_cleared;

    // Table port and remainder unit.
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_mem_addr;
    logic [CNT_W-1:0]    w_mem_wdata;
    logic [CNT_W-1:0]    w_mem_rdata;
    logic [CORE_W-1:0]   w_core_sel;
    logic [IRQ_W-1:0]    w_irq_sel;
    logic [CNT_W-1:0]    w_inc;
    logic [CORE_W-1:0]   w_last;
    logic                w_in_range;
    logic                w_accept;
    t_mod_req            w_mod_req;
    t_mod_rsp            w_mod_rsp;

    lilr_count_mem #(
        .DEPTH (DEPTH)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    lilr_mod_unit u_mod_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // Configuration writes; unknown indexes do not exist in a two-bit field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_io_mode    <= 1'b0;
            r_balance_en     <= 1'b0;
            r_active_cores   <= ACT_W'(1);
            r_balance_period <= PERIOD_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SYM_IO_MODE:    r_sym_io_mode    <= i_cfg_data[0];
                REG_BALANCE_ENABLE: r_balance_en     <= i_cfg_data[0];
                REG_ACTIVE_CORES:   r_active_cores   <= i_cfg_data[ACT_W-1:0];
                REG_BALANCE_PERIOD: r_balance_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input checks and the last scanned core, clamped to 0 .. MAX_CORES-1.
    assign w_in_range = (7'(i_core_id) < 7'(MAX_CORES)) && (7'(i_irq_line) < 7'(MAX_IRQS));
    assign w_accept   = i_valid && o_ready;
    assign w_inc      = w_mem_rdata + 1'b1;

    always_comb begin
        if (r_active_cores == '0) begin
            w_last = '0;
        end else if (7'(r_active_cores) > 7'(MAX_CORES)) begin
            w_last = CORE_W'(MAX_CORES - 1);
        end else begin
            w_last = CORE_W'(r_active_cores - 1'b1);
        end
    end

    // Table address: core-major, IRQ-minor.
    always_comb begin
        w_core_sel = r_scan;
        w_irq_sel  = r_irq;
        case (r_state)
            S_IDLE: begin
                w_core_sel = CORE_W'(i_core_id);
                w_irq_sel  = IRQ_W'(i_irq_line);
            end
            S_INC: begin
                w_core_sel = r_core;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_mem_addr = r_clr_addr;
        end else begin
            w_mem_addr = ADDR_W'(ADDR_W'(w_core_sel) * ADDR_W'(MAX_IRQS))
                       + ADDR_W'(w_irq_sel);
        end
        w_mem_we    = (r_state == S_CLEAR) || (r_state == S_INC) || (r_state == S_WIPE);
        w_mem_wdata = (r_state == S_INC) ? w_inc : '0;
    end

    // Remainder check starts on the incremented count when balancing applies.
    assign w_mod_req.start    = (r_state == S_INC) && r_balance_en
                             && (r_balance_period != '0) && (w_inc != '0);
    assign w_mod_req.dividend = w_inc;
    assign w_mod_req.divisor  = r_balance_period;

    // Sequencer.
    always_comb begin
        n_state           = r_state;
        n_clr_addr        = r_clr_addr;
        n_scan            = r_scan;
        n_irq             = r_irq;
        n_core            = r_core;
        n_eoi             = r_eoi;
        n_best            = r_best;
        n_best_core       = r_best_core;
        n_clear           = r_clear;
        n_res_route_valid = r_res_route_valid;
        n_out_valid       = r_out_valid && !i_ready;
        n_out_eoi         = r_out_eoi;
        n_out_route_valid = r_out_route_valid;
        n_out_route       = r_out_route;
        n_out_cleared     = r_out_cleared;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_irq             = IRQ_W'(i_irq_line);
                    n_core            = CORE_W'(i_core_id);
                    n_eoi             = r_sym_io_mode;
                    n_best_core       = '0;
                    n_clear           = 1'b0;
                    n_res_route_valid = 1'b0;
                    n_state           = w_in_range ? S_INC : S_EMIT;
                end
            end
            S_INC: begin
                n_state = w_mod_req.start ? S_MOD : S_EMIT;
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    if (w_mod_rsp.rem_zero) begin
                        n_best            = ALL_ONES;
                        n_best_core       = '0;
                        n_clear           = 1'b0;
                        n_scan            = '0;
                        n_res_route_valid = 1'b1;
                        n_state           = S_SCAN_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // First lowest count wins; a near-full count that is not a new
                // minimum requests a clear of the IRQ's counts.
                if (w_mem_rdata < r_best) begin
                    n_best      = w_mem_rdata;
                    n_best_core = r_scan;
                end else if (w_mem_rdata >= NEAR_FULL) begin
                    n_clear = 1'b1;
                end
                if (r_scan == w_last) begin
                    n_scan  = '0;
                    n_state = n_clear ? S_WIPE : S_EMIT;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_WIPE: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == CORE_W'(MAX_CORES - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid       = 1'b1;
                    n_out_eoi         = r_eoi;
                    n_out_route_valid = r_res_route_valid;
                    n_out_route       = r_res_route_valid ? FIELD_W'(r_best_core) : '0;
                    n_out_cleared     = r_res_route_valid && r_clear;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_irq             <= n_irq;
        r_core            <= n_core;
        r_eoi             <= n_eoi;
        r_best            <= n_best;
        r_best_core       <= n_best_core;
        r_clear           <= n_clear;
        r_res_route_valid <= n_res_route_valid;
        r_out_eoi         <= n_out_eoi;
        r_out_route_valid <= n_out_route_valid;
        r_out_route       <= n_out_route;
        r_out_cleared     <= n_out_cleared;
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_eoi_to_local_apic = r_out_eoi;
    assign o_route_valid       = r_out_route_valid;
    assign o_route_core        = r_out_route;
    assign o_counts_cleared    = r_out_cleared;

    // Checks on the result word and the sequencer.
    `LILR_ASSERT_IMP(a_no_route_fields, i_clk, i_rst_n, o_valid && !o_route_valid, (o_route_core == '0) && !o_counts_cleared)
    `LILR_ASSERT_IMP(a_clear_needs_route, i_clk, i_rst_n, o_valid && o_counts_cleared, o_route_valid)
    `LILR_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `LILR_ASSERT_IMP(a_mod_done_in_mod, i_clk, i_rst_n, w_mod_rsp.done, r_state == S_MOD)

endmodule
